// File: hw/rtl/eav_pkg.sv
package eav_pkg;

  // Byte codes the parser looks for
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // qtext range
  localparam logic [7:0] QTEXT_LO = 8'd33;
  localparam logic [7:0] QTEXT_HI = 8'd126;

  // Domain length counter saturates here; also the minimum length
  localparam logic [1:0] DOMAIN_LEN_MIN = 2'd3;

  // Parse phase of the current address
  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_ATOM    = 3'd1,
    PH_QOPEN   = 3'd2,
    PH_QCLOSED = 3'd3,
    PH_DOMAIN  = 3'd4
  } phase_t;

  // Class of the previous domain byte
  typedef enum logic [1:0] {
    DC_NONE   = 2'd0,
    DC_DOT    = 2'd1,
    DC_HYPHEN = 2'd2,
    DC_OTHER  = 2'd3
  } dclass_t;

  // One classified byte, as queued between front and back
  typedef struct packed {
    logic last;
    logic high;
    logic is_at;
    logic is_dot;
    logic is_hyphen;
    logic is_quote;
    logic is_bslash;
    logic is_alnum;
    logic atom_char;
    logic quoted_char;
  } class_t;

  // Queue fill status
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// File: hw/rtl/eav_if.sv
// Byte stream channel
interface eav_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;

  modport source (output valid, char_byte, last_byte, input ready);
  modport sink   (input valid, char_byte, last_byte, output ready);
endinterface

// Verdict channel
interface eav_out_if;
  logic valid;
  logic ready;
  logic address_valid;

  modport source (output valid, address_valid, input ready);
  modport sink   (input valid, address_valid, output ready);
endinterface

// File: hw/rtl/eav_classify.sv
module eav_classify (
  eav_in_if.sink             addr_stream,
  input  eav_pkg::queue_status_t q_status,
  output logic               push,
  output eav_pkg::class_t    entry
);

  logic [7:0] b;

  assign b = addr_stream.char_byte;

  // Take a byte whenever the queue has room
  assign addr_stream.ready = !q_status.full;
  assign push              = addr_stream.valid && !q_status.full;

  // Per-byte character classes
  always_comb begin
    entry.last      = addr_stream.last_byte;
    entry.high      = b[7];
    entry.is_at     = (b == eav_pkg::CH_AT);
    entry.is_dot    = (b == eav_pkg::CH_DOT);
    entry.is_hyphen = (b == eav_pkg::CH_HYPHEN);
    entry.is_quote  = (b == eav_pkg::CH_QUOTE);
    entry.is_bslash = (b == eav_pkg::CH_BSLASH);
    entry.is_alnum  = b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]};
    // atext: alnum plus the specials, '-' included, '.' excluded
    entry.atom_char = entry.is_alnum ||
                      (b inside {8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A,
                                 8'h2B, 8'h2D, 8'h2F, 8'h3D, 8'h3F, 8'h5E, 8'h5F,
                                 8'h60, 8'h7B, 8'h7C, 8'h7D, 8'h7E});
    entry.quoted_char = (b >= eav_pkg::QTEXT_LO) && (b <= eav_pkg::QTEXT_HI) &&
                        !entry.is_quote && !entry.is_bslash;
  end

endmodule

// File: hw/rtl/eav_queue.sv
module eav_queue #(
  parameter int DEPTH = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  eav_pkg::class_t        push_entry,
  input  logic                   pop,
  output eav_pkg::class_t        head,
  output eav_pkg::queue_status_t status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  eav_pkg::class_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign head         = slots[rd_ptr];
  assign status.empty = (count == '0);
  // Reported full during reset so no item is taken then
  assign status.full  = rst || (count == FULL_CNT);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

// File: hw/rtl/eav_parse.sv
module eav_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  eav_pkg::class_t        head,
  input  eav_pkg::queue_status_t q_status,
  output logic                   pop,
  eav_out_if.source              verdict
);

  eav_pkg::phase_t  phase, phase_next;
  eav_pkg::dclass_t prev_class, prev_class_next;
  logic       escape_pending, escape_pending_next;
  logic       local_prev_dot, local_prev_dot_next;
  logic       at_label_start, at_label_start_next;
  logic       domain_has_dot, domain_has_dot_next;
  logic [1:0] domain_len, domain_len_next;
  logic       failed, failed_next;
  logic       ok_next;
  logic       out_valid;
  logic       out_value;

  // Pop unless a last byte would overwrite an untaken verdict
  assign pop = !q_status.empty && (!head.last || !out_valid || verdict.ready);

  assign verdict.valid         = out_valid;
  assign verdict.address_valid = out_value;

  // Per-byte parse rules
  always_comb begin
    phase_next          = phase;
    prev_class_next     = prev_class;
    escape_pending_next = escape_pending;
    local_prev_dot_next = local_prev_dot;
    at_label_start_next = at_label_start;
    domain_has_dot_next = domain_has_dot;
    domain_len_next     = domain_len;
    failed_next         = failed || head.high;

    if (phase == eav_pkg::PH_DOMAIN) begin
      if (!(head.is_alnum || head.is_hyphen || head.is_dot)) begin
        failed_next = 1'b1;
      end else begin
        if (head.is_dot) begin
          if (at_label_start || prev_class == eav_pkg::DC_HYPHEN) begin
            failed_next = 1'b1;
          end
          domain_has_dot_next = 1'b1;
          at_label_start_next = 1'b1;
          prev_class_next     = eav_pkg::DC_DOT;
        end else begin
          if (at_label_start && head.is_hyphen) begin
            failed_next = 1'b1;
          end
          at_label_start_next = 1'b0;
          prev_class_next     = head.is_hyphen ? eav_pkg::DC_HYPHEN : eav_pkg::DC_OTHER;
        end
        if (domain_len != eav_pkg::DOMAIN_LEN_MIN) begin
          domain_len_next = domain_len + 2'd1;
        end
      end
    end else if (head.is_at) begin
      // Split point: local part must be complete
      if (phase == eav_pkg::PH_START || phase == eav_pkg::PH_QOPEN) begin
        failed_next = 1'b1;
      end
      if (phase == eav_pkg::PH_ATOM && local_prev_dot) begin
        failed_next = 1'b1;
      end
      phase_next          = eav_pkg::PH_DOMAIN;
      escape_pending_next = 1'b0;
    end else begin
      case (phase)
        eav_pkg::PH_START: begin
          if (head.is_quote) begin
            phase_next = eav_pkg::PH_QOPEN;
          end else if (head.atom_char) begin
            phase_next          = eav_pkg::PH_ATOM;
            local_prev_dot_next = 1'b0;
          end else begin
            failed_next         = 1'b1;
            phase_next          = eav_pkg::PH_ATOM;
            local_prev_dot_next = head.is_dot;
          end
        end
        eav_pkg::PH_ATOM: begin
          if (head.is_dot) begin
            if (local_prev_dot) begin
              failed_next = 1'b1;
            end
            local_prev_dot_next = 1'b1;
          end else begin
            if (!head.atom_char) begin
              failed_next = 1'b1;
            end
            local_prev_dot_next = 1'b0;
          end
        end
        eav_pkg::PH_QOPEN: begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
          end else if (head.is_bslash) begin
            escape_pending_next = 1'b1;
          end else if (head.is_quote) begin
            phase_next = eav_pkg::PH_QCLOSED;
          end else if (!head.quoted_char) begin
            failed_next = 1'b1;
          end
        end
        default: begin
          // anything after the closing quote other than '@'
          failed_next = 1'b1;
        end
      endcase
    end

    ok_next = !failed_next && phase_next == eav_pkg::PH_DOMAIN &&
              domain_len_next == eav_pkg::DOMAIN_LEN_MIN && domain_has_dot_next &&
              prev_class_next == eav_pkg::DC_OTHER;
  end

  // Parse state, cleared after each last byte
  always_ff @(posedge clk) begin
    if (rst || (pop && head.last)) begin
      phase          <= eav_pkg::PH_START;
      prev_class     <= eav_pkg::DC_NONE;
      escape_pending <= 1'b0;
      local_prev_dot <= 1'b0;
      at_label_start <= 1'b1;
      domain_has_dot <= 1'b0;
      domain_len     <= '0;
      failed         <= 1'b0;
    end else if (pop) begin
      phase          <= phase_next;
      prev_class     <= prev_class_next;
      escape_pending <= escape_pending_next;
      local_prev_dot <= local_prev_dot_next;
      at_label_start <= at_label_start_next;
      domain_has_dot <= domain_has_dot_next;
      domain_len     <= domain_len_next;
      failed         <= failed_next;
    end
  end

  // Verdict output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.last) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      out_value <= ok_next;
    end
  end

endmodule

// File: hw/rtl/email_address_validator_core.sv
// Channel       Dir  Payload                         Item
// addr_stream   in   char_byte[7:0], last_byte       one byte of an address
// verdict       out  address_valid                   one verdict per address
//
// One byte per cycle sustained while no verdict is stalled; the classifier writes a
// small queue and the parser takes one queued byte per cycle.
// A last byte passes the queue slot, then the verdict register, before its verdict shows.
// rst is synchronous and empties the queue, clears the parse state and the verdict.
// A stalled verdict holds only the parser at a last byte; the queue still fills.
module email_address_validator_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic        clk,
  input logic        rst,
  eav_in_if.sink     addr_stream,
  eav_out_if.source  verdict
);

  eav_pkg::class_t        in_entry;
  eav_pkg::class_t        head;
  eav_pkg::queue_status_t q_status;
  logic                   push;
  logic                   pop;

  // Front: accept and classify
  eav_classify u_classify (
    .addr_stream (addr_stream),
    .q_status    (q_status),
    .push        (push),
    .entry       (in_entry)
  );

  // Decoupling queue
  eav_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (in_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // Back: parse and report
  eav_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .verdict  (verdict)
  );

  // Queue cannot be empty and full at once
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.empty && q_status.full))
    else $error("queue empty and full together");

  // A byte taken into an empty queue is present on the next cycle
  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    (push && q_status.empty) |=> !q_status.empty)
    else $error("accepted byte lost from queue");

  // A new verdict appears only after a last byte was parsed
  a_verdict_src: assert property (@(posedge clk) disable iff (rst)
    $rose(verdict.valid) |-> $past(pop && head.last))
    else $error("verdict without a last byte");

  // A waiting verdict is never overwritten by the next address
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (!q_status.empty && head.last && verdict.valid && !verdict.ready) |-> !pop)
    else $error("verdict overwritten while stalled");

endmodule

// File: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // How a directed address gets its expected verdict
  typedef enum {WANT_MODEL, WANT_VALID, WANT_INVALID} verdict_want_t;

  // Receiver stall patterns
  typedef enum {RX_STEADY, RX_COIN, RX_SPARSE} rx_pattern_t;

  typedef struct {
    string         text;
    int            nul_at;  // byte index sent as 8'h00, -1 for none
    verdict_want_t want;
  } directed_addr_t;

  localparam string ALNUM_CHARS =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";
  localparam string ATEXT_PUNCT = "!#$%&'*+/=?^_{|}~-";

  logic clk = 1'b0;
  logic rst = 1'b1;

  eav_in_if  addr_stream ();
  eav_out_if verdict ();

  email_address_validator_core u_top (
    .clk         (clk),
    .rst         (rst),
    .addr_stream (addr_stream),
    .verdict     (verdict)
  );

  always #5 clk = ~clk;

  // Short directed addresses: extremes and the corner cases of the grammar
  directed_addr_t directed_addrs [10] = '{
    '{"a@b.c",               -1, WANT_VALID},    // shortest good address
    '{"x",                    0, WANT_INVALID},  // a lone NUL, no '@'
    '{"@",                   -1, WANT_INVALID},  // empty local part and empty domain
    '{"\"@",                 -1, WANT_INVALID},  // '@' inside an open quote
    '{"\"\\@",               -1, WANT_INVALID},  // '@' with an escape pending
    '{"\"\"x@",              -1, WANT_INVALID},  // byte after the closing quote
    '{"a@b@",                -1, WANT_INVALID},  // second '@' in the domain
    '{"\377",                -1, WANT_INVALID},  // top byte value
    '{"\200@b.c",            -1, WANT_INVALID},  // high byte, rest cannot repair it
    '{"\"~\\\177\"@b.c",     -1, WANT_MODEL}     // quoted local part, escaped DEL
  };

  // Parser state mirror
  eav_pkg::phase_t  ph;
  eav_pkg::dclass_t prev_class;
  logic       esc_pending;
  logic       atom_prev_dot;
  logic       lbl_head;
  logic       dom_has_dot;
  logic [1:0] dom_len;
  logic       addr_failed;

  logic       expected_verdicts [$];
  logic [7:0] addr_bytes [$];
  int         mismatch_count = 0;
  int         verdict_count = 0;
  int         burst_left = 0;
  bit         holdoff_request = 1'b0;

  function automatic void clear_parser();
    ph            = eav_pkg::PH_START;
    esc_pending   = 1'b0;
    atom_prev_dot = 1'b0;
    lbl_head      = 1'b1;
    prev_class    = eav_pkg::DC_NONE;
    dom_has_dot   = 1'b0;
    dom_len       = 2'd0;
    addr_failed   = 1'b0;
  endfunction

  function automatic logic is_alnum(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  function automatic logic atom_char(logic [7:0] b);
    case (b)
      "!", "#", "$", "%", "&", "'", "*", "+", "/", "=", "?", "^",
      "_", 8'h60, "{", "|", "}", "~", eav_pkg::CH_HYPHEN: return 1'b1;
      default: return is_alnum(b);
    endcase
  endfunction

  // Advance the mirror by one byte; on a last byte, give the verdict and clear
  function automatic void parse_address_byte(input logic [7:0] b, input logic lst,
                                             output logic has_verdict, output logic ok);
    if (b[7]) addr_failed = 1'b1;
    if (ph == eav_pkg::PH_DOMAIN) begin
      if (!(is_alnum(b) || b == eav_pkg::CH_HYPHEN || b == eav_pkg::CH_DOT)) begin
        addr_failed = 1'b1;
      end else begin
        if (b == eav_pkg::CH_DOT) begin
          if (lbl_head || prev_class == eav_pkg::DC_HYPHEN) addr_failed = 1'b1;
          dom_has_dot = 1'b1;
          lbl_head    = 1'b1;
          prev_class  = eav_pkg::DC_DOT;
        end else begin
          if (lbl_head && b == eav_pkg::CH_HYPHEN) addr_failed = 1'b1;
          lbl_head    = 1'b0;
          prev_class  = (b == eav_pkg::CH_HYPHEN) ? eav_pkg::DC_HYPHEN : eav_pkg::DC_OTHER;
        end
        if (dom_len < eav_pkg::DOMAIN_LEN_MIN) dom_len = dom_len + 2'd1;
      end
    end else if (b == eav_pkg::CH_AT) begin
      if (ph == eav_pkg::PH_START || ph == eav_pkg::PH_QOPEN) addr_failed = 1'b1;
      if (ph == eav_pkg::PH_ATOM && atom_prev_dot) addr_failed = 1'b1;
      ph          = eav_pkg::PH_DOMAIN;
      esc_pending = 1'b0;
    end else begin
      case (ph)
        eav_pkg::PH_START: begin
          if (b == eav_pkg::CH_QUOTE) begin
            ph = eav_pkg::PH_QOPEN;
          end else if (atom_char(b)) begin
            ph            = eav_pkg::PH_ATOM;
            atom_prev_dot = 1'b0;
          end else begin
            addr_failed   = 1'b1;
            ph            = eav_pkg::PH_ATOM;
            atom_prev_dot = (b == eav_pkg::CH_DOT);
          end
        end
        eav_pkg::PH_ATOM: begin
          if (b == eav_pkg::CH_DOT) begin
            if (atom_prev_dot) addr_failed = 1'b1;
            atom_prev_dot = 1'b1;
          end else begin
            if (!atom_char(b)) addr_failed = 1'b1;
            atom_prev_dot = 1'b0;
          end
        end
        eav_pkg::PH_QOPEN: begin
          if (esc_pending) begin
            esc_pending = 1'b0;
          end else if (b == eav_pkg::CH_BSLASH) begin
            esc_pending = 1'b1;
          end else if (b == eav_pkg::CH_QUOTE) begin
            ph = eav_pkg::PH_QCLOSED;
          end else if (b < eav_pkg::QTEXT_LO || b > eav_pkg::QTEXT_HI) begin
            addr_failed = 1'b1;
          end
        end
        default: addr_failed = 1'b1;
      endcase
    end
    has_verdict = lst;
    ok = !addr_failed && ph == eav_pkg::PH_DOMAIN &&
         dom_len >= eav_pkg::DOMAIN_LEN_MIN && dom_has_dot &&
         prev_class == eav_pkg::DC_OTHER;
    if (lst) clear_parser();
  endfunction

  function automatic logic [7:0] pick_char(string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  // Random address: mostly well formed, some mutated, some pure noise
  function automatic void build_random_address();
    int         kind;
    int         n;
    logic [7:0] c;
    addr_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 8)) addr_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      // quoted local part with qtext and escapes
      addr_bytes.push_back(eav_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 4)) begin
        if ($urandom_range(0, 3) == 0) begin
          addr_bytes.push_back(eav_pkg::CH_BSLASH);
          addr_bytes.push_back(8'($urandom_range(0, 127)));
        end else begin
          do c = 8'($urandom_range(eav_pkg::QTEXT_LO, eav_pkg::QTEXT_HI));
          while (c == eav_pkg::CH_QUOTE || c == eav_pkg::CH_BSLASH);
          addr_bytes.push_back(c);
        end
      end
      addr_bytes.push_back(eav_pkg::CH_QUOTE);
    end else begin
      // dot-atom
      n = $urandom_range(1, 3);
      for (int a = 0; a < n; a++) begin
        if (a > 0) addr_bytes.push_back(eav_pkg::CH_DOT);
        repeat ($urandom_range(1, 3))
          addr_bytes.push_back($urandom_range(0, 2) == 0 ? pick_char(ATEXT_PUNCT)
                                                         : pick_char(ALNUM_CHARS));
      end
    end
    addr_bytes.push_back(eav_pkg::CH_AT);
    // domain labels, hyphens only inside a label
    n = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 3);
    for (int l = 0; l < n; l++) begin
      int len;
      len = $urandom_range(1, 4);
      if (l > 0) addr_bytes.push_back(eav_pkg::CH_DOT);
      for (int j = 0; j < len; j++)
        addr_bytes.push_back((j > 0 && j < len - 1 && $urandom_range(0, 3) == 0) ?
                             eav_pkg::CH_HYPHEN : pick_char(ALNUM_CHARS));
    end
    // broken sequences
    if (kind >= 7) begin
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 4))
          0: c = eav_pkg::CH_DOT;
          1: c = eav_pkg::CH_HYPHEN;
          2: c = eav_pkg::CH_AT;
          3: c = eav_pkg::CH_QUOTE;
          default: c = 8'($urandom_range(0, 255));
        endcase
        addr_bytes[$urandom_range(0, addr_bytes.size() - 1)] = c;
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offer one byte, in bursts with random gaps; predict on acceptance
  task automatic drive_byte(input logic [7:0] b, input logic lst, input verdict_want_t want);
    logic has_verdict;
    logic ok;
    if (burst_left == 0) begin
      addr_stream.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    addr_stream.valid     <= 1'b1;
    addr_stream.char_byte <= b;
    addr_stream.last_byte <= lst;
    do begin
      @(posedge clk);
    end while (!addr_stream.ready);
    burst_left--;
    parse_address_byte(b, lst, has_verdict, ok);
    if (has_verdict)
      expected_verdicts.push_back(want == WANT_MODEL ? ok : (want == WANT_VALID));
  endtask

  // Stop offering until every outstanding verdict has come back
  task automatic wait_all_verdicts();
    addr_stream.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (expected_verdicts.size() != 0);
  endtask

  // Verdict checker
  always @(posedge clk) begin : verdict_check
    logic want_v;
    if (!rst && verdict.valid && verdict.ready) begin
      verdict_count++;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict %0d: address_valid=%0b with none expected",
                                  verdict_count, verdict.address_valid));
      end else begin
        want_v = expected_verdicts.pop_front();
        if (verdict.address_valid !== want_v)
          report_mismatch($sformatf("verdict %0d: address_valid=%0b, expected %0b",
                                    verdict_count, verdict.address_valid, want_v));
      end
    end
  end

  // Receiver: changing stall patterns plus one long hold-off on request
  initial begin : receiver
    rx_pattern_t rx_mode;
    int          rx_left;
    rx_mode = RX_STEADY;
    rx_left = 0;
    verdict.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_request) begin
        holdoff_request = 1'b0;
        verdict.ready <= 1'b0;
        repeat (80) @(posedge clk);
      end else begin
        if (rx_left == 0) begin
          rx_mode = rx_pattern_t'($urandom_range(0, 2));
          rx_left = $urandom_range(8, 60);
        end
        rx_left--;
        case (rx_mode)
          RX_STEADY: verdict.ready <= 1'b1;
          RX_COIN:   verdict.ready <= 1'($urandom_range(0, 1));
          default:   verdict.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int addresses_sent;
    int bytes_sent;
    addresses_sent = 0;
    bytes_sent     = 0;
    clear_parser();
    addr_stream.valid     <= 1'b0;
    addr_stream.char_byte <= 8'h00;
    addr_stream.last_byte <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_addrs[r]) begin
      for (int i = 0; i < directed_addrs[r].text.len(); i++)
        drive_byte((i == directed_addrs[r].nul_at) ? 8'h00 : directed_addrs[r].text[i],
                   i == directed_addrs[r].text.len() - 1, directed_addrs[r].want);
    end
    wait_all_verdicts();

    // random part tops the directed bytes up to about 450
    while (bytes_sent < 414) begin
      build_random_address();
      // long receiver stall while bytes keep coming; later a full drain
      if (addresses_sent == 8) holdoff_request = 1'b1;
      if (addresses_sent == 20) wait_all_verdicts();
      foreach (addr_bytes[i])
        drive_byte(addr_bytes[i], i == addr_bytes.size() - 1, WANT_MODEL);
      bytes_sent += addr_bytes.size();
      addresses_sent++;
    end

    wait_all_verdicts();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** email_address_validator_core: PASSED **");
    end else begin
      $display("** email_address_validator_core: FAILED **");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("** email_address_validator_core: FAILED **");
    $finish;
  end

endmodule
